// File: src/pcp_pkg.sv
package pcp_pkg;

	localparam int CHAR_W = 8;
	localparam int OUT_W = 8;
	localparam int TOTAL_W = 32;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [CHAR_W-1:0] CH_DIGIT_LO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIGIT_HI = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LOWER_LO = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_HI = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UPPER_LO = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_HI = 8'h5A;

	typedef enum logic [2:0] {
		CLS_NONE    = 3'd0,
		CLS_DIGIT   = 3'd1,
		CLS_LOWER   = 3'd2,
		CLS_UPPER   = 3'd3,
		CLS_SPECIAL = 3'd4
	} pcp_class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_LENGTH     = 8'd0,
		REG_MIN_SPECIAL    = 8'd1,
		REG_MIN_DIGIT      = 8'd2,
		REG_MIN_LOWER      = 8'd3,
		REG_MIN_UPPER      = 8'd4,
		REG_ADVANCED_LIMIT = 8'd5,
		REG_SIMPLE_LIMIT   = 8'd6
	} pcp_reg_idx_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] min_length;
		logic [CFG_DATA_W-1:0] min_special;
		logic [CFG_DATA_W-1:0] min_digit;
		logic [CFG_DATA_W-1:0] min_lower;
		logic [CFG_DATA_W-1:0] min_upper;
		logic [CFG_DATA_W-1:0] advanced_limit;
		logic [CFG_DATA_W-1:0] simple_limit;
	} pcp_cfg_t;

	typedef struct packed {
		logic [OUT_W-1:0]   pass_len;
		logic [OUT_W-1:0]   digit_total;
		logic [OUT_W-1:0]   lower_total;
		logic [OUT_W-1:0]   upper_total;
		logic [OUT_W-1:0]   special_total;
		logic [OUT_W-1:0]   class_runs;
		logic               meets_policy;
		logic               advanced_over;
		logic               simple_over;
		logic [TOTAL_W-1:0] secure_count;
	} pcp_result_t;

endpackage

// File: src/pcp_if.sv
interface pcp_char_if import pcp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;

	modport source (output valid, char_code, last_char, input ready);
	modport sink (input valid, char_code, last_char, output ready);
endinterface

interface pcp_result_if import pcp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OUT_W-1:0]   pass_len;
	logic [OUT_W-1:0]   digit_total;
	logic [OUT_W-1:0]   lower_total;
	logic [OUT_W-1:0]   upper_total;
	logic [OUT_W-1:0]   special_total;
	logic [OUT_W-1:0]   class_runs;
	logic               meets_policy;
	logic               advanced_over;
	logic               simple_over;
	logic [TOTAL_W-1:0] secure_count;

	modport source (output valid, pass_len, digit_total, lower_total, upper_total,
		special_total, class_runs, meets_policy, advanced_over, simple_over,
		secure_count, input ready);
	modport sink (input valid, pass_len, digit_total, lower_total, upper_total,
		special_total, class_runs, meets_policy, advanced_over, simple_over,
		secure_count, output ready);
endinterface

interface pcp_cfg_if import pcp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/pcp_char_class.sv
module pcp_char_class import pcp_pkg::*; (
	input  logic [CHAR_W-1:0] char_code,
	output pcp_class_t        cls
);

	always_comb begin
		case (char_code) inside
			[CH_DIGIT_LO:CH_DIGIT_HI]: cls = CLS_DIGIT;
			[CH_LOWER_LO:CH_LOWER_HI]: cls = CLS_LOWER;
			[CH_UPPER_LO:CH_UPPER_HI]: cls = CLS_UPPER;
			default: cls = CLS_SPECIAL;
		endcase
	end

endmodule

// File: src/pcp_tally.sv
module pcp_tally import pcp_pkg::*; #(
	parameter int COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  pcp_class_t  cls,
	input  logic        last,
	input  pcp_cfg_t    cfg,
	output pcp_result_t result
);

	localparam int CMP_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	typedef logic [COUNT_BITS-1:0] cnt_t;

	cnt_t       len_q, digit_q, lower_q, upper_q, special_q, runs_q;
	pcp_class_t prev_q;
	logic [TOTAL_W-1:0] secure_q;

	cnt_t len_d, digit_d, lower_d, upper_d, special_d, runs_d;
	logic meets;
	logic [TOTAL_W-1:0] secure_d;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

	// Counters wider than the output field show their top value once past it.
	function automatic logic [OUT_W-1:0] to_out(input cnt_t v);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(v);
		return (ext > CMP_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : ext[OUT_W-1:0];
	endfunction

	always_comb begin
		len_d     = sat_inc(len_q);
		digit_d   = (cls == CLS_DIGIT)   ? sat_inc(digit_q)   : digit_q;
		lower_d   = (cls == CLS_LOWER)   ? sat_inc(lower_q)   : lower_q;
		upper_d   = (cls == CLS_UPPER)   ? sat_inc(upper_q)   : upper_q;
		special_d = (cls == CLS_SPECIAL) ? sat_inc(special_q) : special_q;
		runs_d    = (cls != prev_q)      ? sat_inc(runs_q)    : runs_q;

		meets = (CMP_W'(len_d)     >= CMP_W'(cfg.min_length))
		     && (CMP_W'(special_d) >= CMP_W'(cfg.min_special))
		     && (CMP_W'(digit_d)   >= CMP_W'(cfg.min_digit))
		     && (CMP_W'(lower_d)   >= CMP_W'(cfg.min_lower))
		     && (CMP_W'(upper_d)   >= CMP_W'(cfg.min_upper));

		secure_d = (meets && secure_q != {TOTAL_W{1'b1}}) ? secure_q + TOTAL_W'(1) : secure_q;

		result.pass_len      = to_out(len_d);
		result.digit_total   = to_out(digit_d);
		result.lower_total   = to_out(lower_d);
		result.upper_total   = to_out(upper_d);
		result.special_total = to_out(special_d);
		result.class_runs    = to_out(runs_d);
		result.meets_policy  = meets;
		result.advanced_over = CMP_W'(len_d) > CMP_W'(cfg.advanced_limit);
		result.simple_over   = CMP_W'(runs_d) > CMP_W'(cfg.simple_limit);
		result.secure_count  = secure_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			digit_q   <= '0;
			lower_q   <= '0;
			upper_q   <= '0;
			special_q <= '0;
			runs_q    <= '0;
			prev_q    <= CLS_NONE;
			secure_q  <= '0;
		end else if (step) begin
			if (last) begin
				// The password is complete, so the per-password state starts afresh.
				len_q     <= '0;
				digit_q   <= '0;
				lower_q   <= '0;
				upper_q   <= '0;
				special_q <= '0;
				runs_q    <= '0;
				prev_q    <= CLS_NONE;
				secure_q  <= secure_d;
			end else begin
				len_q     <= len_d;
				digit_q   <= digit_d;
				lower_q   <= lower_d;
				upper_q   <= upper_d;
				special_q <= special_d;
				runs_q    <= runs_d;
				prev_q    <= cls;
			end
		end
	end

endmodule

// File: src/password_class_profiler_unit.sv
// Password class profiler.
// Password bytes arrive on the chars channel, one transaction per byte, with
// last_char set on the final byte. Each byte is classed as digit, lower, upper
// or special and counted; runs of one class are counted as well.
// For every final byte one transaction leaves on the summary channel with the
// length, the four class totals, the run count, the policy verdict, the two
// limit flags and the running total of passwords that met the policy.
// Registers are written over the cfg channel (index, data); it is always ready
// and should only be written while no password is in flight.
// Throughput is one byte per cycle while no final byte waits on a stalled
// summary: a byte is held in the input register while the classifier and
// counter update run, and a final byte's summary is loaded into the output
// register as that byte leaves the input register.
// If the receiver stalls, non-final bytes keep flowing; a final byte waits in
// the input register until the held summary has been taken.
// Reset clears all counters and the secure total, sets the minimums to zero
// and both limits to 255.
module password_class_profiler_unit import pcp_pkg::*; #(
	parameter int COUNT_BITS = 8
) (
	input logic          clk,
	input logic          arst_n,
	pcp_char_if.sink     chars,
	pcp_result_if.source summary,
	pcp_cfg_if.sink      cfg
);

	pcp_cfg_t    cfg_q;
	logic        valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic        last_s1;
	logic        advance_s1;
	pcp_class_t  cls_s1;
	pcp_result_t result_d;
	pcp_result_t result_q;
	logic        out_valid_q;
	logic        out_load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length     <= '0;
			cfg_q.min_special    <= '0;
			cfg_q.min_digit      <= '0;
			cfg_q.min_lower      <= '0;
			cfg_q.min_upper      <= '0;
			cfg_q.advanced_limit <= '1;
			cfg_q.simple_limit   <= '1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MIN_LENGTH:     cfg_q.min_length     <= cfg.data;
				REG_MIN_SPECIAL:    cfg_q.min_special    <= cfg.data;
				REG_MIN_DIGIT:      cfg_q.min_digit      <= cfg.data;
				REG_MIN_LOWER:      cfg_q.min_lower      <= cfg.data;
				REG_MIN_UPPER:      cfg_q.min_upper      <= cfg.data;
				REG_ADVANCED_LIMIT: cfg_q.advanced_limit <= cfg.data;
				REG_SIMPLE_LIMIT:   cfg_q.simple_limit   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Only a final byte needs room in the output register.
	assign advance_s1  = valid_s1 && (!last_s1 || !out_valid_q || summary.ready);
	assign chars.ready = !valid_s1 || advance_s1;
	assign out_load    = advance_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
	end

	pcp_char_class u_class (
		.char_code (char_s1),
		.cls       (cls_s1)
	);

	pcp_tally #(
		.COUNT_BITS (COUNT_BITS)
	) u_tally (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance_s1),
		.cls    (cls_s1),
		.last   (last_s1),
		.cfg    (cfg_q),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (summary.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= result_d;
		end
	end

	assign summary.valid         = out_valid_q;
	assign summary.pass_len      = result_q.pass_len;
	assign summary.digit_total   = result_q.digit_total;
	assign summary.lower_total   = result_q.lower_total;
	assign summary.upper_total   = result_q.upper_total;
	assign summary.special_total = result_q.special_total;
	assign summary.class_runs    = result_q.class_runs;
	assign summary.meets_policy  = result_q.meets_policy;
	assign summary.advanced_over = result_q.advanced_over;
	assign summary.simple_over   = result_q.simple_over;
	assign summary.secure_count  = result_q.secure_count;

	// A password that met the policy is itself in the secure total.
	a_secure_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.meets_policy |-> result_q.secure_count != '0)
		else $error("secure total is zero on a passing password");

	// Every password has at least one run and never more runs than bytes.
	a_runs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.class_runs != '0)
			&& (result_q.class_runs <= result_q.pass_len))
		else $error("run count out of bounds");

	// A final byte held back by a stalled summary must not be overwritten.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance_s1 |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("input register changed while stalled");

endmodule

// File: tb/testbench.sv
module testbench;
	import pcp_pkg::*;

	localparam int COUNT_BITS = 8;
	localparam int unsigned OUT_MAX = (1 << OUT_W) - 1;
	localparam int SETTLE_CYCLES = 4;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_SIMPLE_LIMIT + 1'b1;

	typedef enum int {SHAPE_MIXED, SHAPE_ALTERNATE, SHAPE_DIGITS} pw_shape_t;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              fin;
	} char_item_t;

	logic clk;
	logic arst_n;

	pcp_char_if   chars_if ();
	pcp_result_if summary_if ();
	pcp_cfg_if    cfg_if ();

	password_class_profiler_unit #(.COUNT_BITS(COUNT_BITS)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.summary (summary_if),
		.cfg     (cfg_if)
	);

	char_item_t  pending[$];
	char_item_t  next_char;
	pcp_result_t summary_expect[$];

	// Shadow copy of the registers and of the per-password counters.
	pcp_cfg_t              policy;
	logic [COUNT_BITS-1:0] seen_len, seen_digit, seen_lower, seen_upper;
	logic [COUNT_BITS-1:0] seen_special, seen_runs;
	pcp_class_t            last_class;
	logic [TOTAL_W-1:0]    secure_seen;

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  char_fire;
	bit  byte_fire;
	bit  sum_fire;
	int  idle_cycles;
	int  bytes_queued;
	int  bytes_taken;
	int  errors;
	int  results_checked;
	int  policy_hits;
	int  adv_hits;
	int  simple_hits;
	int  cfg_writes;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic pcp_class_t class_of(logic [CHAR_W-1:0] code);
		if (code >= CH_DIGIT_LO && code <= CH_DIGIT_HI) return CLS_DIGIT;
		if (code >= CH_LOWER_LO && code <= CH_LOWER_HI) return CLS_LOWER;
		if (code >= CH_UPPER_LO && code <= CH_UPPER_HI) return CLS_UPPER;
		return CLS_SPECIAL;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
		return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_W-1:0] narrow(logic [COUNT_BITS-1:0] v);
		int unsigned wide;
		wide = 32'(v);
		return (wide > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(wide);
	endfunction

	function automatic void clear_profile();
		seen_len = '0;
		seen_digit = '0;
		seen_lower = '0;
		seen_upper = '0;
		seen_special = '0;
		seen_runs = '0;
		last_class = CLS_NONE;
	endfunction

	// Updates the counters for one accepted byte; a final byte yields the summary
	// that the block must produce.
	function automatic void profile_byte(logic [CHAR_W-1:0] code, logic fin);
		pcp_class_t  cls;
		pcp_result_t want;
		logic        meets;
		cls = class_of(code);
		case (cls)
			CLS_DIGIT: seen_digit = sat_inc(seen_digit);
			CLS_LOWER: seen_lower = sat_inc(seen_lower);
			CLS_UPPER: seen_upper = sat_inc(seen_upper);
			default: seen_special = sat_inc(seen_special);
		endcase
		seen_len = sat_inc(seen_len);
		if (cls != last_class) begin
			seen_runs = sat_inc(seen_runs);
			last_class = cls;
		end
		if (fin) begin
			meets = seen_len >= policy.min_length && seen_special >= policy.min_special &&
				seen_digit >= policy.min_digit && seen_lower >= policy.min_lower &&
				seen_upper >= policy.min_upper;
			if (meets && secure_seen != '1)
				secure_seen = secure_seen + 1'b1;
			want.pass_len = narrow(seen_len);
			want.digit_total = narrow(seen_digit);
			want.lower_total = narrow(seen_lower);
			want.upper_total = narrow(seen_upper);
			want.special_total = narrow(seen_special);
			want.class_runs = narrow(seen_runs);
			want.meets_policy = meets;
			want.advanced_over = seen_len > policy.advanced_limit;
			want.simple_over = seen_runs > policy.simple_limit;
			want.secure_count = secure_seen;
			summary_expect.push_back(want);
			clear_profile();
		end
	endfunction

	function automatic void check_field(string fname, logic [TOTAL_W-1:0] want,
		logic [TOTAL_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endfunction

	function automatic void check_summary();
		pcp_result_t want;
		if (summary_expect.size() == 0) begin
			errors++;
			$display("%0t: summary transaction with no password pending, actual len %0d",
				$time, summary_if.pass_len);
			return;
		end
		want = summary_expect.pop_front();
		results_checked++;
		policy_hits += want.meets_policy;
		adv_hits += want.advanced_over;
		simple_hits += want.simple_over;
		check_field("pass_len", TOTAL_W'(want.pass_len), TOTAL_W'(summary_if.pass_len));
		check_field("digit_total", TOTAL_W'(want.digit_total),
			TOTAL_W'(summary_if.digit_total));
		check_field("lower_total", TOTAL_W'(want.lower_total),
			TOTAL_W'(summary_if.lower_total));
		check_field("upper_total", TOTAL_W'(want.upper_total),
			TOTAL_W'(summary_if.upper_total));
		check_field("special_total", TOTAL_W'(want.special_total),
			TOTAL_W'(summary_if.special_total));
		check_field("class_runs", TOTAL_W'(want.class_runs),
			TOTAL_W'(summary_if.class_runs));
		check_field("meets_policy", TOTAL_W'(want.meets_policy),
			TOTAL_W'(summary_if.meets_policy));
		check_field("advanced_over", TOTAL_W'(want.advanced_over),
			TOTAL_W'(summary_if.advanced_over));
		check_field("simple_over", TOTAL_W'(want.simple_over),
			TOTAL_W'(summary_if.simple_over));
		check_field("secure_count", want.secure_count, summary_if.secure_count);
	endfunction

	// Byte driver: a new byte is offered once the previous one has been taken.
	always @(negedge clk) begin
		summary_if.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
		end else if (!chars_if.valid || char_fire) begin
			if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_char = pending.pop_front();
				chars_if.valid <= 1'b1;
				chars_if.char_code <= next_char.code;
				chars_if.last_char <= next_char.fin;
			end else begin
				chars_if.valid <= 1'b0;
			end
		end
	end

	// Monitor: predicts from accepted bytes first, so that a summary is never
	// compared before its own expectation exists.
	always @(posedge clk) begin
		byte_fire = arst_n && chars_if.valid && chars_if.ready;
		sum_fire = arst_n && summary_if.valid && summary_if.ready;
		char_fire <= byte_fire;
		if (byte_fire || sum_fire || (cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (byte_fire) begin
			bytes_taken++;
			profile_byte(chars_if.char_code, chars_if.last_char);
		end
		if (sum_fire)
			check_summary();
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_CYCLES);
		$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_CYCLES);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic push_char(input logic [CHAR_W-1:0] code, input logic fin);
		char_item_t item;
		item.code = code;
		item.fin = fin;
		pending.push_back(item);
		bytes_queued++;
	endtask

	function automatic logic [CHAR_W-1:0] char_of(pcp_class_t cls);
		logic [CHAR_W-1:0] code;
		case (cls)
			CLS_DIGIT: code = CH_DIGIT_LO + CHAR_W'($urandom_range(0, CH_DIGIT_HI - CH_DIGIT_LO));
			CLS_LOWER: code = CH_LOWER_LO + CHAR_W'($urandom_range(0, CH_LOWER_HI - CH_LOWER_LO));
			CLS_UPPER: code = CH_UPPER_LO + CHAR_W'($urandom_range(0, CH_UPPER_HI - CH_UPPER_LO));
			default: begin
				code = CHAR_W'($urandom_range(0, 255));
				while (class_of(code) != CLS_SPECIAL)
					code = CHAR_W'($urandom_range(0, 255));
			end
		endcase
		return code;
	endfunction

	task automatic add_password(input int len, input pw_shape_t shape);
		pcp_class_t        cls;
		logic [CHAR_W-1:0] code;
		cls = CLS_SPECIAL;
		for (int i = 0; i < len; i++) begin
			case (shape)
				SHAPE_DIGITS: cls = CLS_DIGIT;
				SHAPE_ALTERNATE: cls = pcp_class_t'(i % 4 + 1);
				default: begin
					if (i == 0 || $urandom_range(0, 1) == 0)
						cls = pcp_class_t'($urandom_range(1, 4));
				end
			endcase
			code = char_of(cls);
			if (shape == SHAPE_MIXED && $urandom_range(0, 7) == 0)
				code = CHAR_W'($urandom_range(0, 255));
			push_char(code, i == len - 1);
		end
	endtask

	// Holds the feeder until every byte has been taken and every summary checked.
	task automatic drain();
		while (!(bytes_taken == bytes_queued && summary_expect.size() == 0))
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			REG_MIN_LENGTH: policy.min_length = val;
			REG_MIN_SPECIAL: policy.min_special = val;
			REG_MIN_DIGIT: policy.min_digit = val;
			REG_MIN_LOWER: policy.min_lower = val;
			REG_MIN_UPPER: policy.min_upper = val;
			REG_ADVANCED_LIMIT: policy.advanced_limit = val;
			REG_SIMPLE_LIMIT: policy.simple_limit = val;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic program_policy(input int len_min, input int spec_min, input int dig_min,
		input int low_min, input int up_min, input int adv_lim, input int simple_lim);
		drain();
		write_reg(REG_MIN_LENGTH, CFG_DATA_W'(len_min));
		write_reg(REG_MIN_SPECIAL, CFG_DATA_W'(spec_min));
		write_reg(REG_MIN_DIGIT, CFG_DATA_W'(dig_min));
		write_reg(REG_MIN_LOWER, CFG_DATA_W'(low_min));
		write_reg(REG_MIN_UPPER, CFG_DATA_W'(up_min));
		write_reg(REG_ADVANCED_LIMIT, CFG_DATA_W'(adv_lim));
		write_reg(REG_SIMPLE_LIMIT, CFG_DATA_W'(simple_lim));
	endtask

	task automatic random_passwords(input int budget);
		int spent;
		int len;
		int count;
		spent = 0;
		count = 0;
		while (spent < budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			add_password(len, ($urandom_range(0, 7) == 0) ? SHAPE_ALTERNATE : SHAPE_MIXED);
			spent += len;
			count++;
			// Now and then the sender stops until the block has emptied.
			if (count % 6 == 0)
				drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.char_code = '0;
		chars_if.last_char = 1'b0;
		summary_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		send_idle_pct = 27;
		recv_idle_pct = 49;
		policy = '{min_length: '0, min_special: '0, min_digit: '0, min_lower: '0,
			min_upper: '0, advanced_limit: '1, simple_limit: '1};
		secure_seen = '0;
		clear_profile();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Class boundaries and raw extremes as one-byte passwords, then a four-byte one, reset policy.
		push_char(CH_DIGIT_LO, 1'b1);
		push_char(CH_DIGIT_HI, 1'b1);
		push_char(CH_LOWER_LO, 1'b1);
		push_char(CH_LOWER_HI, 1'b1);
		push_char(CH_UPPER_LO, 1'b1);
		push_char(CH_UPPER_HI, 1'b1);
		push_char(CH_DIGIT_LO - 1'b1, 1'b1);
		push_char(CH_DIGIT_HI + 1'b1, 1'b1);
		push_char(CH_LOWER_LO - 1'b1, 1'b1);
		push_char(CH_LOWER_HI + 1'b1, 1'b1);
		push_char(CH_UPPER_LO - 1'b1, 1'b1);
		push_char(CH_UPPER_HI + 1'b1, 1'b1);
		push_char('0, 1'b1);
		push_char('1, 1'b1);
		push_char({1'b1, {(CHAR_W-1){1'b0}}}, 1'b1);
		push_char(CH_LOWER_LO, 1'b0);
		push_char(CH_LOWER_LO, 1'b0);
		push_char(CH_UPPER_LO, 1'b0);
		push_char(CH_DIGIT_LO, 1'b1);

		// Every class required once, both limits at zero; writes to unused
		// indexes must leave the policy alone.
		program_policy(1, 1, 1, 1, 1, 0, 0);
		write_reg(REG_UNUSED, '0);
		write_reg(CFG_IDX_W'($urandom_range(int'(REG_UNUSED) + 1, 255)), '1);
		push_char(CH_LOWER_HI, 1'b0);
		push_char(CH_DIGIT_HI, 1'b0);
		push_char(CH_UPPER_HI, 1'b0);
		push_char(CH_DIGIT_LO - 1'b1, 1'b1);
		push_char(CH_LOWER_HI, 1'b0);
		push_char(CH_LOWER_HI, 1'b1);

		program_policy($urandom_range(0, 4), $urandom_range(0, 2), $urandom_range(0, 2),
			$urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(3, 12),
			$urandom_range(1, 6));
		random_passwords(60);

		drain();
		send_idle_pct = 49;
		recv_idle_pct = 27;
		program_policy($urandom_range(0, 10), $urandom_range(0, 2), $urandom_range(0, 2),
			$urandom_range(0, 3), $urandom_range(0, 2), 255, 0);
		random_passwords(60);

		// A long alternating password saturates the length and run counters.
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_policy(255, 0, 0, 0, 0, 254, 254);
		add_password(260, SHAPE_ALTERNATE);
		random_passwords(30);

		drain();
		if (summary_expect.size() != 0) begin
			errors++;
			$display("%0t: %0d summaries never arrived", $time, summary_expect.size());
		end
		$display("Profiled %0d passwords from %0d bytes over %0d register writes.",
			results_checked, bytes_taken, cfg_writes);
		$display("Policy met %0d times, length limit exceeded %0d, run limit exceeded %0d.",
			policy_hits, adv_hits, simple_hits);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
